// ===== rtl/ibru_pkg.sv =====
// ----------------------------------------------------------------------------
// ibru_pkg
// Types, opcode field codes and flag helpers for the indexed bit/rotate unit.
// ----------------------------------------------------------------------------
package ibru_pkg;

	typedef logic [15:0] addr_t;
	typedef logic [7:0]  byte_t;
	typedef logic [2:0]  reg_idx_t;
	typedef logic [4:0]  cyc_t;

	// opcode bits 7..6
	typedef enum logic [1:0] {
		GRP_SHIFT = 2'd0,
		GRP_BIT   = 2'd1,
		GRP_RES   = 2'd2,
		GRP_SET   = 2'd3
	} op_group_t;

	// opcode bits 5..3 within the shift group
	typedef enum logic [2:0] {
		SH_RLC = 3'd0,
		SH_RRC = 3'd1,
		SH_RL  = 3'd2,
		SH_RR  = 3'd3,
		SH_SLA = 3'd4,
		SH_SRA = 3'd5,
		SH_SLL = 3'd6,
		SH_SRL = 3'd7
	} shift_kind_t;

	// F register bit positions
	localparam int unsigned FL_C_BIT  = 0;
	localparam int unsigned FL_N_BIT  = 1;
	localparam int unsigned FL_PV_BIT = 2;
	localparam int unsigned FL_3_BIT  = 3;
	localparam int unsigned FL_H_BIT  = 4;
	localparam int unsigned FL_5_BIT  = 5;
	localparam int unsigned FL_Z_BIT  = 6;
	localparam int unsigned FL_S_BIT  = 7;

	localparam reg_idx_t NO_COPY = 3'd6;
	localparam cyc_t     CYC_BIT = 5'd20;
	localparam cyc_t     CYC_RMW = 5'd23;

	// S, Z, 5, 3 and even parity of a result byte, with H, N and C clear
	function automatic byte_t sz53p(input byte_t v);
		byte_t f;
		f                 = '0;
		f[FL_S_BIT]       = v[7];
		f[FL_5_BIT]       = v[5];
		f[FL_3_BIT]       = v[3];
		f[FL_Z_BIT]       = (v == 8'h00);
		f[FL_PV_BIT]      = ~^v;
		return f;
	endfunction

endpackage

// ===== rtl/indexed_bit_rotate_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_bit_rotate_unit
// Executes one indexed bit instruction (rotate/shift, BIT, RES, SET) on a
// memory byte: forms the address, the new byte, the new flags, the copy
// register and the T-state count.
//
//   channel | signals                                         | dir
//   --------+-------------------------------------------------+-----
//   in      | in_valid in_stall index_base displacement       | in
//           | opcode mem_value flags_in                       |
//   out     | out_valid out_stall access_address write_enable | out
//           | result_value copy_register flags_out cycle_count|
//
// A beat passes through an input register, then one pass of decode and bit
// logic into the result register.
// One beat is taken every cycle while the result side keeps up.
// A stalled result holds; a beat can still enter an empty input register then.
// arst_n clears both valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
module indexed_bit_rotate_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ibru_pkg::addr_t     index_base,
	input  logic signed [7:0]   displacement,
	input  ibru_pkg::byte_t     opcode,
	input  ibru_pkg::byte_t     mem_value,
	input  ibru_pkg::byte_t     flags_in,
	output logic                out_valid,
	input  logic                out_stall,
	output ibru_pkg::addr_t     access_address,
	output logic                write_enable,
	output ibru_pkg::byte_t     result_value,
	output ibru_pkg::reg_idx_t  copy_register,
	output ibru_pkg::byte_t     flags_out,
	output ibru_pkg::cyc_t      cycle_count
);
	import ibru_pkg::*;

	logic        valid_s1;
	addr_t       base_s1;
	byte_t       disp_s1;
	byte_t       op_s1;
	byte_t       val_s1;
	byte_t       fin_s1;

	logic        valid_q;
	addr_t       addr_q;
	logic        we_q;
	byte_t       res_q;
	reg_idx_t    reg_q;
	byte_t       flags_q;
	cyc_t        cyc_q;

	logic        adv_out;
	logic        adv_s1;

	addr_t       addr_c;
	op_group_t   grp_c;
	logic [2:0]  sel_c;
	byte_t       mask_c;
	logic        tbit_c;
	logic        cy_c;
	byte_t       shres_c;
	logic        we_c;
	byte_t       res_c;
	reg_idx_t    reg_c;
	byte_t       flags_c;
	cyc_t        cyc_c;

	// advance when the next stage is empty or draining
	assign adv_out  = !valid_q || !out_stall;
	assign adv_s1   = !valid_s1 || adv_out;
	assign in_stall = !adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			base_s1 <= index_base;
			disp_s1 <= displacement;
			op_s1   <= opcode;
			val_s1  <= mem_value;
			fin_s1  <= flags_in;
		end
	end

	// decode opcode fields and form the address with wrap
	assign addr_c = base_s1 + {{8{disp_s1[7]}}, disp_s1};
	assign grp_c  = op_group_t'(op_s1[7:6]);
	assign sel_c  = op_s1[5:3];
	assign mask_c = byte_t'(8'h01 << sel_c);
	assign tbit_c = val_s1[sel_c];

	// rotate or shift the byte
	always_comb begin
		case (shift_kind_t'(sel_c))
			SH_RLC: begin cy_c = val_s1[7]; shres_c = {val_s1[6:0], val_s1[7]}; end
			SH_RRC: begin cy_c = val_s1[0]; shres_c = {val_s1[0], val_s1[7:1]}; end
			SH_RL:  begin
				cy_c    = val_s1[7];
				shres_c = {val_s1[6:0], fin_s1[FL_C_BIT]};
			end
			SH_RR:  begin
				cy_c    = val_s1[0];
				shres_c = {fin_s1[FL_C_BIT], val_s1[7:1]};
			end
			SH_SLA: begin cy_c = val_s1[7]; shres_c = {val_s1[6:0], 1'b0}; end
			SH_SRA: begin cy_c = val_s1[0]; shres_c = {val_s1[7], val_s1[7:1]}; end
			SH_SLL: begin cy_c = val_s1[7]; shres_c = {val_s1[6:0], 1'b1}; end
			default: begin cy_c = val_s1[0]; shres_c = {1'b0, val_s1[7:1]}; end
		endcase
	end

	// select result, flags and write-back per group
	always_comb begin
		we_c    = 1'b1;
		res_c   = val_s1;
		reg_c   = op_s1[2:0];
		flags_c = fin_s1;
		cyc_c   = CYC_RMW;
		case (grp_c)
			GRP_SHIFT: begin
				res_c   = shres_c;
				flags_c = sz53p(shres_c) | {7'b0, cy_c};
			end
			GRP_BIT: begin
				we_c                = 1'b0;
				res_c               = '0;
				reg_c               = NO_COPY;
				cyc_c               = CYC_BIT;
				flags_c             = '0;
				flags_c[FL_C_BIT]   = fin_s1[FL_C_BIT];
				flags_c[FL_H_BIT]   = 1'b1;
				flags_c[FL_Z_BIT]   = !tbit_c;
				flags_c[FL_PV_BIT]  = !tbit_c;
				flags_c[FL_S_BIT]   = tbit_c && (sel_c == 3'd7);
				flags_c[FL_5_BIT]   = addr_c[8 + FL_5_BIT];
				flags_c[FL_3_BIT]   = addr_c[8 + FL_3_BIT];
			end
			GRP_RES: begin
				res_c = val_s1 & ~mask_c;
			end
			default: begin
				res_c = val_s1 | mask_c;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv_out) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			addr_q  <= addr_c;
			we_q    <= we_c;
			res_q   <= res_c;
			reg_q   <= reg_c;
			flags_q <= flags_c;
			cyc_q   <= cyc_c;
		end
	end

	assign out_valid      = valid_q;
	assign access_address = addr_q;
	assign write_enable   = we_q;
	assign result_value   = res_q;
	assign copy_register  = reg_q;
	assign flags_out      = flags_q;
	assign cycle_count    = cyc_q;

	// the input side only stalls behind a full input register
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_q && out_stall))
		else $error("input stalled without a blocked item ahead");

	// write enable and cycle count agree
	a_we_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (write_enable == (cycle_count == CYC_RMW)))
		else $error("write enable and cycle count disagree");

	// BIT results carry no copy, a zero byte and H set
	a_bit_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !write_enable) |->
		(copy_register == NO_COPY && result_value == 8'h00 && flags_out[FL_H_BIT]))
		else $error("BIT result fields wrong");

	// an item in the input register moves on once the result side drains
	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_stall) |=> out_valid)
		else $error("item lost between input and result register");

endmodule

// ===== tb/sv/tb_indexed_bit_rotate_unit.sv =====
// ----------------------------------------------------------------------------
// tb_indexed_bit_rotate_unit
// Self-checking bench for the indexed bit/rotate unit. Each accepted beat is
// run through a local model of the instruction group (address wrap, shifts,
// BIT, RES, SET), and the expected outcome is queued. Every result beat is
// checked field by field against the oldest queued outcome. Directed beats
// cover the edge cases. Random beats follow, with random gaps and stalls on
// both channels, a back-to-back stretch and a long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb_indexed_bit_rotate_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ibru_pkg::*;

	localparam int unsigned STUCK_LIMIT    = 1000;
	localparam int unsigned HOLDOFF_CYCLES = 80;
	localparam int unsigned MAX_PRINTED    = 30;

	typedef struct packed {
		addr_t    addr;
		logic     we;
		byte_t    value;
		reg_idx_t copy_reg;
		byte_t    flags;
		cyc_t     cycles;
	} rmw_outcome_t;

	logic              clk;
	logic              arst_n       = 1'b0;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	addr_t             index_base   = '0;
	logic signed [7:0] displacement = '0;
	byte_t             opcode       = '0;
	byte_t             mem_value    = '0;
	byte_t             flags_in     = '0;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	addr_t             access_address;
	logic              write_enable;
	byte_t             result_value;
	reg_idx_t          copy_register;
	byte_t             flags_out;
	cyc_t              cycle_count;

	rmw_outcome_t      pending_outcomes[$];
	int unsigned       mismatch_count = 0;
	bit                tx_no_gaps     = 1'b0;
	bit                rx_no_stall    = 1'b0;
	int unsigned       holdoff_req    = 0;

	indexed_bit_rotate_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.index_base     (index_base),
		.displacement   (displacement),
		.opcode         (opcode),
		.mem_value      (mem_value),
		.flags_in       (flags_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.access_address (access_address),
		.write_enable   (write_enable),
		.result_value   (result_value),
		.copy_register  (copy_register),
		.flags_out      (flags_out),
		.cycle_count    (cycle_count)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic byte_t make_op(op_group_t grp, logic [2:0] sel, reg_idx_t dst);
		return {grp, sel, dst};
	endfunction

	// compute what one indexed bit instruction must produce
	function automatic rmw_outcome_t exec_indexed_op(addr_t base, logic [7:0] disp,
			byte_t op, byte_t mem, byte_t fl);
		rmw_outcome_t o;
		logic [2:0]   sel;
		logic         cy;
		byte_t        r;
		sel        = op[5:3];
		o.addr     = base + {{8{disp[7]}}, disp};
		o.we       = 1'b1;
		o.value    = mem;
		o.copy_reg = op[2:0];
		o.flags    = fl;
		o.cycles   = CYC_RMW;
		case (op_group_t'(op[7:6]))
			GRP_SHIFT: begin
				case (shift_kind_t'(sel))
					SH_RLC: begin cy = mem[7]; r = {mem[6:0], mem[7]}; end
					SH_RRC: begin cy = mem[0]; r = {mem[0], mem[7:1]}; end
					SH_RL:  begin cy = mem[7]; r = {mem[6:0], fl[FL_C_BIT]}; end
					SH_RR:  begin cy = mem[0]; r = {fl[FL_C_BIT], mem[7:1]}; end
					SH_SLA: begin cy = mem[7]; r = {mem[6:0], 1'b0}; end
					SH_SRA: begin cy = mem[0]; r = {mem[7], mem[7:1]}; end
					SH_SLL: begin cy = mem[7]; r = {mem[6:0], 1'b1}; end
					default: begin cy = mem[0]; r = {1'b0, mem[7:1]}; end
				endcase
				o.value            = r;
				o.flags            = '0;
				o.flags[FL_S_BIT]  = r[7];
				o.flags[FL_Z_BIT]  = (r == 8'h00);
				o.flags[FL_5_BIT]  = r[5];
				o.flags[FL_3_BIT]  = r[3];
				o.flags[FL_PV_BIT] = ~^r;
				o.flags[FL_C_BIT]  = cy;
			end
			GRP_BIT: begin
				o.flags            = '0;
				o.flags[FL_S_BIT]  = (sel == 3'd7) && mem[7];
				o.flags[FL_Z_BIT]  = ~mem[sel];
				o.flags[FL_5_BIT]  = o.addr[8 + FL_5_BIT];
				o.flags[FL_H_BIT]  = 1'b1;
				o.flags[FL_3_BIT]  = o.addr[8 + FL_3_BIT];
				o.flags[FL_PV_BIT] = ~mem[sel];
				o.flags[FL_C_BIT]  = fl[FL_C_BIT];
				o.we               = 1'b0;
				o.value            = '0;
				o.copy_reg         = NO_COPY;
				o.cycles           = CYC_BIT;
			end
			GRP_RES: begin
				o.value      = mem;
				o.value[sel] = 1'b0;
			end
			default: begin
				o.value      = mem;
				o.value[sel] = 1'b1;
			end
		endcase
		return o;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		if (mismatch_count < MAX_PRINTED)
			$display("%0t ns: %s mismatch: got 0x%0h, want 0x%0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// offer one beat, hold it until taken, then queue its outcome
	task automatic send_instr(addr_t base, logic [7:0] disp, byte_t op, byte_t mem, byte_t fl);
		int unsigned gap;
		gap = tx_no_gaps ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		index_base   <= base;
		displacement <= disp;
		opcode       <= op;
		mem_value    <= mem;
		flags_in     <= fl;
		do
			@(posedge clk);
		while (in_stall);
		pending_outcomes.push_back(exec_indexed_op(base, disp, op, mem, fl));
	endtask

	task automatic send_random_instr();
		addr_t base;
		case ($urandom_range(0, 4))
			0: base = addr_t'($urandom_range(0, 127));
			1: base = addr_t'($urandom_range(16'hFF80, 16'hFFFF));
			default: base = addr_t'($urandom_range(0, 16'hFFFF));
		endcase
		send_instr(base, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	// displacement extremes and wrap of the 16-bit address
	task automatic test_address_wrap();
		send_instr(16'h0000, 8'h80, make_op(GRP_SET, 3'd7, NO_COPY), 8'h00, 8'h00);
		send_instr(16'hFFFF, 8'h7F, make_op(GRP_RES, 3'd0, 3'd7), 8'hFF, 8'hFF);
		send_instr(16'h8000, 8'h00, make_op(GRP_SHIFT, SH_RLC, 3'd0), 8'h80, 8'h00);
		send_instr(16'h7FFF, 8'hFF, make_op(GRP_SHIFT, SH_SRL, 3'd5), 8'h7F, 8'hFF);
	endtask

	// every shift kind, every copy register, carry-in and zero results
	task automatic test_shift_kinds();
		for (int k = 0; k < 8; k++)
			send_instr(16'h1234, 8'(k * 17), make_op(GRP_SHIFT, 3'(k), 3'(k)),
				8'h81 ^ 8'(k << 2), (k % 2) ? 8'hFF : 8'h00);
		send_instr(16'h4000, 8'h01, make_op(GRP_SHIFT, SH_RL, 3'd1), 8'h00, 8'h01);
		send_instr(16'h4000, 8'hFE, make_op(GRP_SHIFT, SH_RR, 3'd2), 8'h00, 8'h01);
		send_instr(16'hC000, 8'h10, make_op(GRP_SHIFT, SH_SLA, NO_COPY), 8'h80, 8'h00);
		send_instr(16'hC000, 8'hF0, make_op(GRP_SHIFT, SH_SLL, 3'd4), 8'h00, 8'hFE);
	endtask

	// tested bit set and clear, sign only on bit 7, bits 5 and 3 from the address
	task automatic test_bit_tests();
		send_instr(16'h0000, 8'h00, make_op(GRP_BIT, 3'd7, 3'd0), 8'h80, 8'h00);
		send_instr(16'hFFFF, 8'h01, make_op(GRP_BIT, 3'd7, 3'd7), 8'h7F, 8'hFF);
		send_instr(16'h2800, 8'h05, make_op(GRP_BIT, 3'd0, NO_COPY), 8'hFE, 8'h01);
		send_instr(16'hD7FF, 8'h00, make_op(GRP_BIT, 3'd3, 3'd3), 8'h08, 8'hFE);
	endtask

	task automatic test_res_set();
		send_instr(16'hABCD, 8'h80, make_op(GRP_RES, 3'd7, NO_COPY), 8'hFF, 8'h55);
		send_instr(16'h5432, 8'h7F, make_op(GRP_SET, 3'd0, 3'd1), 8'h00, 8'hAA);
		send_instr(16'h0101, 8'hC3, make_op(GRP_SET, 3'd4, 3'd7), 8'hEF, 8'h00);
	endtask

	task automatic test_random_mix(int unsigned count);
		repeat (count) send_random_instr();
	endtask

	// full rate on both sides
	task automatic test_back_to_back(int unsigned count);
		tx_no_gaps  = 1'b1;
		rx_no_stall = 1'b1;
		repeat (count) send_random_instr();
		tx_no_gaps  = 1'b0;
		rx_no_stall = 1'b0;
	endtask

	// stall the result side for a long stretch while beats keep coming
	task automatic test_output_holdoff(int unsigned count);
		// drop the last beat so it is not taken again while waiting
		in_valid <= 1'b0;
		@(posedge clk);
		holdoff_req = HOLDOFF_CYCLES;
		wait (holdoff_req == 0);
		tx_no_gaps = 1'b1;
		repeat (count) send_random_instr();
		tx_no_gaps = 1'b0;
	endtask

	// result-side stall pattern, plus the long hold-off on request
	always begin : result_stall_gen
		int unsigned n;
		@(posedge clk);
		if (holdoff_req != 0) begin
			n           = holdoff_req;
			holdoff_req = 0;
			out_stall <= 1'b1;
			repeat (n) @(posedge clk);
			out_stall <= 1'b0;
		end else if (rx_no_stall) begin
			out_stall <= 1'b0;
		end else begin
			n = pick_gap();
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	// check each result beat against the oldest pending outcome
	always @(posedge clk) begin : result_check
		rmw_outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch("unexpected result beat, access_address", access_address, 0);
			end else begin
				want = pending_outcomes.pop_front();
				if (access_address !== want.addr)
					report_mismatch("access_address", access_address, want.addr);
				if (write_enable !== want.we)
					report_mismatch("write_enable", write_enable, want.we);
				if (result_value !== want.value)
					report_mismatch("result_value", result_value, want.value);
				if (copy_register !== want.copy_reg)
					report_mismatch("copy_register", copy_register, want.copy_reg);
				if (flags_out !== want.flags)
					report_mismatch("flags_out", flags_out, want.flags);
				if (cycle_count !== want.cycles)
					report_mismatch("cycle_count", cycle_count, want.cycles);
			end
		end
	end

	// end the run when no beat moves for too long
	initial begin : stuck_watchdog
		int unsigned stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck = 0;
			else
				stuck++;
		end
		$display("indexed_bit_rotate_unit regression: fail");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_address_wrap();
		test_shift_kinds();
		test_bit_tests();
		test_res_set();
		test_random_mix(500);
		test_back_to_back(150);
		test_output_holdoff(40);
		test_random_mix(450);

		// drain
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		if (mismatch_count == 0)
			$display("indexed_bit_rotate_unit regression: pass");
		else
			$display("indexed_bit_rotate_unit regression: fail");
		$finish;
	end

endmodule
